/* src/aepq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aepq_pkg: shared types and constants
// Opcodes, field widths, controller states and the search result record of
// the active/expired priority queue scheduler.
// ----------------------------------------------------------------------------
package aepq_pkg;

	localparam int ID_W  = 8;
	localparam int LVL_W = 4;
	localparam int CFG_W = 5;

	// Reset value of the level count register
	localparam logic [CFG_W-1:0] NUM_LEVELS_RST = 5'd4;

	localparam logic OP_ADD      = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_POP,
		ST_LINK
	} state_t;

	// Outcome of the level search for a dispatch
	typedef struct packed {
		logic             found;
		logic             swap;
		logic             bank;
		logic [LVL_W-1:0] lvl;
	} sel_t;

endpackage

/* src/aepq_pick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aepq_pick: dispatch level search
// Finds the highest non-empty level of the active bank below the level count,
// falling back to the other bank (with a swap) when the active bank is empty.
// ----------------------------------------------------------------------------
module aepq_pick #(
	parameter int MAX_LEVELS = 16
) (
	input  logic [2*MAX_LEVELS-1:0]      nonempty,
	input  logic                         active,
	input  logic [aepq_pkg::CFG_W-1:0]   count,
	output aepq_pkg::sel_t               sel
);

	// Only levels reachable through the 4-bit level field can ever hold tasks
	localparam int SRCH = (MAX_LEVELS < 16) ? MAX_LEVELS : 16;

	logic [MAX_LEVELS-1:0]           bank0;
	logic [MAX_LEVELS-1:0]           bank1;
	logic [MAX_LEVELS-1:0]           cur;
	logic [MAX_LEVELS-1:0]           oth;
	logic                            hit_c;
	logic                            hit_o;
	logic [aepq_pkg::LVL_W-1:0]      lvl_c;
	logic [aepq_pkg::LVL_W-1:0]      lvl_o;

	assign bank0 = nonempty[MAX_LEVELS-1:0];
	assign bank1 = nonempty[2*MAX_LEVELS-1:MAX_LEVELS];
	assign cur   = active ? bank1 : bank0;
	assign oth   = active ? bank0 : bank1;

	// Priority encode both banks; the highest qualifying level wins
	always_comb begin
		hit_c = 1'b0;
		hit_o = 1'b0;
		lvl_c = '0;
		lvl_o = '0;
		for (int l = 0; l < SRCH; l++) begin
			if (cur[l] && (5'(l) < count)) begin
				hit_c = 1'b1;
				lvl_c = 4'(l);
			end
			if (oth[l] && (5'(l) < count)) begin
				hit_o = 1'b1;
				lvl_o = 4'(l);
			end
		end
	end

	always_comb begin
		sel.swap  = !hit_c;
		sel.found = hit_c || hit_o;
		sel.bank  = hit_c ? active : !active;
		sel.lvl   = hit_c ? lvl_c : (hit_o ? lvl_o : '0);
	end

endmodule

/* src/aepq_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aepq_store: queue head, queue tail and task link memories
// Synchronous memories with one write port each and registered read data.
// ----------------------------------------------------------------------------
module aepq_store #(
	parameter int MAX_LEVELS = 16,
	parameter int MAX_TASKS  = 256
) (
	input  logic                                clk,
	input  logic                                q_re,
	input  logic [$clog2(2*MAX_LEVELS)-1:0]     q_raddr,
	output logic [aepq_pkg::ID_W-1:0]           head_rd,
	output logic [aepq_pkg::ID_W-1:0]           tail_rd,
	input  logic [$clog2(2*MAX_LEVELS)-1:0]     q_waddr,
	input  logic                                head_we,
	input  logic [aepq_pkg::ID_W-1:0]           head_wdata,
	input  logic                                tail_we,
	input  logic [aepq_pkg::ID_W-1:0]           tail_wdata,
	input  logic                                link_re,
	input  logic [$clog2(MAX_TASKS)-1:0]        link_raddr,
	output logic [aepq_pkg::ID_W-1:0]           link_rd,
	input  logic                                link_we,
	input  logic [$clog2(MAX_TASKS)-1:0]        link_waddr,
	input  logic [aepq_pkg::ID_W-1:0]           link_wdata
);

	logic [aepq_pkg::ID_W-1:0] head_mem [2*MAX_LEVELS];
	logic [aepq_pkg::ID_W-1:0] tail_mem [2*MAX_LEVELS];
	logic [aepq_pkg::ID_W-1:0] link_mem [MAX_TASKS];
	logic [aepq_pkg::ID_W-1:0] head_q;
	logic [aepq_pkg::ID_W-1:0] tail_q;
	logic [aepq_pkg::ID_W-1:0] link_q;

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[q_waddr] <= head_wdata;
		end
		if (tail_we) begin
			tail_mem[q_waddr] <= tail_wdata;
		end
		if (q_re) begin
			head_q <= head_mem[q_raddr];
			tail_q <= tail_mem[q_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (link_re) begin
			link_q <= link_mem[link_raddr];
		end
	end

	assign head_rd = head_q;
	assign tail_rd = tail_q;
	assign link_rd = link_q;

endmodule

/* src/active_expired_priority_queues.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// active_expired_priority_queues: two-bank multilevel task scheduler
// Active and expired banks of FIFO task queues, one per level, kept as linked
// lists in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op/task_id/level/expired with start; a transfer
//   happens at a rising edge with start high and busy low. op add appends
//   task_id at its level (expired bank when expired is set); op dispatch pops
//   the oldest task of the highest non-empty active level, swapping the banks
//   first when the active bank is empty.
//   Result channel: every command returns one result, shown for one cycle
//   with done high. It cannot be held off; capture it when done is high.
//   done is registered from the ADD or POP state that the command transfer
//   enters, and the result is taken at the following edge.
//   Busy: an add passes through ADD and a dispatch through POP; a dispatch
//   that leaves tasks behind also passes through LINK, which writes the new
//   head fetched by the link memory read. No command is taken while busy.
//   Config: cfg_we writes cfg_wdata into the level count; write only while
//   the block is idle.
//   Reset: all queues empty, bank 0 active, level count 4. The memories need
//   no clearing pass, so a command may be issued right after reset.
// ----------------------------------------------------------------------------
module active_expired_priority_queues #(
	parameter int MAX_LEVELS = 16,
	parameter int MAX_TASKS  = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [aepq_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                               start,
	output logic                               busy,
	input  logic                               op,
	input  logic [aepq_pkg::ID_W-1:0]          task_id,
	input  logic [aepq_pkg::LVL_W-1:0]         level,
	input  logic                               expired,
	output logic                               done,
	output logic                               found,
	output logic [aepq_pkg::ID_W-1:0]          chosen_id,
	output logic [aepq_pkg::LVL_W-1:0]         chosen_level,
	output logic                               banks_swapped,
	output logic                               refused
);

	localparam int QW  = $clog2(2*MAX_LEVELS);
	localparam int LAW = $clog2(MAX_TASKS);

	aepq_pkg::state_t                  state_q;
	aepq_pkg::state_t                  state_nxt;
	logic [aepq_pkg::CFG_W-1:0]        num_levels_q;
	logic [aepq_pkg::CFG_W-1:0]        lvl_count;
	logic                              active_q;
	logic [2*MAX_LEVELS-1:0]           nonempty_q;
	aepq_pkg::sel_t                    sel;

	// Per-command registers
	logic [aepq_pkg::ID_W-1:0]         tid_q;
	logic [QW-1:0]                     qidx_q;
	logic                              refused_q;
	logic                              found_q;
	logic                              swap_q;
	logic [aepq_pkg::LVL_W-1:0]        lvl_q;

	// Result output registers
	logic                              done_q;
	logic                              res_found_q;
	logic [aepq_pkg::ID_W-1:0]         res_id_q;
	logic [aepq_pkg::LVL_W-1:0]        res_lvl_q;
	logic                              res_swap_q;
	logic                              res_refused_q;

	logic                              accept;
	logic                              add_bank;
	logic [QW-1:0]                     q_add;
	logic [QW-1:0]                     q_pick;
	logic [QW-1:0]                     q_acc;
	logic                              refuse_acc;

	logic [aepq_pkg::ID_W-1:0]         head_rd;
	logic [aepq_pkg::ID_W-1:0]         tail_rd;
	logic [aepq_pkg::ID_W-1:0]         link_rd;

	// Controls from the output decode
	logic                              q_re;
	logic                              head_we;
	logic [aepq_pkg::ID_W-1:0]         head_wdata;
	logic                              tail_we;
	logic                              link_we;
	logic                              link_re;
	logic                              ne_set;
	logic                              ne_clr;
	logic                              swap_now;
	logic                              res_fire;
	logic                              res_found;
	logic [aepq_pkg::ID_W-1:0]         res_id;
	logic [aepq_pkg::LVL_W-1:0]        res_lvl;
	logic                              res_swap;
	logic                              res_refused;

	assign busy   = (state_q != aepq_pkg::ST_IDLE);
	assign accept = start && !busy;

	// Level count saturates at the number of levels built
	assign lvl_count = (32'(num_levels_q) > MAX_LEVELS) ? 5'(MAX_LEVELS) : num_levels_q;

	aepq_pick #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_pick (
		.nonempty (nonempty_q),
		.active   (active_q),
		.count    (lvl_count),
		.sel      (sel)
	);

	// Queue table index of an add and of a dispatch
	assign add_bank   = expired ? !active_q : active_q;
	assign q_add      = add_bank ? (QW'(MAX_LEVELS) + QW'(level)) : QW'(level);
	assign q_pick     = sel.bank ? (QW'(MAX_LEVELS) + QW'(sel.lvl)) : QW'(sel.lvl);
	assign q_acc      = (op == aepq_pkg::OP_ADD) ? q_add : q_pick;
	assign refuse_acc = ({1'b0, level} >= lvl_count) || (32'(task_id) >= MAX_TASKS);

	aepq_store #(
		.MAX_LEVELS (MAX_LEVELS),
		.MAX_TASKS  (MAX_TASKS)
	) u_store (
		.clk        (clk),
		.q_re       (q_re),
		.q_raddr    (q_acc),
		.head_rd    (head_rd),
		.tail_rd    (tail_rd),
		.q_waddr    (qidx_q),
		.head_we    (head_we),
		.head_wdata (head_wdata),
		.tail_we    (tail_we),
		.tail_wdata (tid_q),
		.link_re    (link_re),
		.link_raddr (LAW'(head_rd)),
		.link_rd    (link_rd),
		.link_we    (link_we),
		.link_waddr (LAW'(tail_rd)),
		.link_wdata (tid_q)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			aepq_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = (op == aepq_pkg::OP_ADD) ? aepq_pkg::ST_ADD : aepq_pkg::ST_POP;
				end
			end
			aepq_pkg::ST_ADD: begin
				state_nxt = aepq_pkg::ST_IDLE;
			end
			aepq_pkg::ST_POP: begin
				// A queue whose head differs from its tail needs its new head fetched
				state_nxt = (found_q && (head_rd != tail_rd)) ? aepq_pkg::ST_LINK
				                                               : aepq_pkg::ST_IDLE;
			end
			aepq_pkg::ST_LINK: begin
				state_nxt = aepq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = aepq_pkg::ST_IDLE;
			end
		endcase
	end

	// Output decode
	always_comb begin
		q_re        = 1'b0;
		head_we     = 1'b0;
		head_wdata  = tid_q;
		tail_we     = 1'b0;
		link_we     = 1'b0;
		link_re     = 1'b0;
		ne_set      = 1'b0;
		ne_clr      = 1'b0;
		swap_now    = 1'b0;
		res_fire    = 1'b0;
		res_found   = 1'b0;
		res_id      = '0;
		res_lvl     = '0;
		res_swap    = 1'b0;
		res_refused = 1'b0;
		case (state_q)
			aepq_pkg::ST_IDLE: begin
				// Read the queue entry in the transfer cycle; swap banks at once
				q_re     = start;
				swap_now = start && (op == aepq_pkg::OP_DISPATCH) && sel.swap;
			end
			aepq_pkg::ST_ADD: begin
				res_fire    = 1'b1;
				res_refused = refused_q;
				if (!refused_q) begin
					tail_we = 1'b1;
					if (nonempty_q[qidx_q]) begin
						link_we = 1'b1;
					end else begin
						head_we = 1'b1;
						ne_set  = 1'b1;
					end
				end
			end
			aepq_pkg::ST_POP: begin
				res_fire  = 1'b1;
				res_found = found_q;
				res_swap  = swap_q;
				if (found_q) begin
					res_id  = head_rd;
					res_lvl = lvl_q;
					if (head_rd == tail_rd) begin
						ne_clr = 1'b1;
					end else begin
						link_re = 1'b1;
					end
				end
			end
			aepq_pkg::ST_LINK: begin
				// Advance the head to the successor of the popped task
				head_we    = 1'b1;
				head_wdata = link_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= aepq_pkg::ST_IDLE;
			num_levels_q <= aepq_pkg::NUM_LEVELS_RST;
			active_q     <= 1'b0;
			nonempty_q   <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= res_fire;
			if (cfg_we) begin
				num_levels_q <= cfg_wdata;
			end
			if (swap_now) begin
				active_q <= !active_q;
			end
			if (ne_set) begin
				nonempty_q[qidx_q] <= 1'b1;
			end
			if (ne_clr) begin
				nonempty_q[qidx_q] <= 1'b0;
			end
		end
	end

	// Hold the command fields for the read-modify-write
	always_ff @(posedge clk) begin
		if (accept) begin
			tid_q     <= task_id;
			qidx_q    <= q_acc;
			refused_q <= refuse_acc;
			found_q   <= sel.found;
			swap_q    <= sel.swap;
			lvl_q     <= sel.lvl;
		end
		if (res_fire) begin
			res_found_q   <= res_found;
			res_id_q      <= res_id;
			res_lvl_q     <= res_lvl;
			res_swap_q    <= res_swap;
			res_refused_q <= res_refused;
		end
	end

	assign done          = done_q;
	assign found         = res_found_q;
	assign chosen_id     = res_id_q;
	assign chosen_level  = res_lvl_q;
	assign banks_swapped = res_swap_q;
	assign refused       = res_refused_q;

`ifndef ASSERT_OFF
	a_result_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result missing two cycles after a command transfer");

	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == aepq_pkg::ST_ADD || state_q == aepq_pkg::ST_POP))
		else $error("result strobe without a command in progress");

	a_link_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aepq_pkg::ST_LINK |=> state_q == aepq_pkg::ST_IDLE)
		else $error("head update did not finish in one cycle");

	a_pop_clears_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		ne_clr |-> (state_q == aepq_pkg::ST_POP) && found_q && nonempty_q[qidx_q])
		else $error("queue emptied without a dispatched task");

	a_swap_on_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q != $past(active_q)) |-> $past(accept && op == aepq_pkg::OP_DISPATCH))
		else $error("bank swap outside a dispatch transfer");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for active_expired_priority_queues
// Runs a short directed sequence and then random add/dispatch traffic over
// several level counts. A shadow scheduler in the bench predicts every result
// at the moment its command transfers. Each done pulse is compared field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAX_LEVELS    = 16;
	localparam int MAX_TASKS     = 256;
	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 7;
	localparam int IDLE_PCT      = 36;
	// Transfer numbers between which the command side never idles
	localparam int CALM_FROM     = 400;
	localparam int CALM_TO       = 700;
	// Quiet cycles required before a level count write. This covers the
	// result latency plus the trailing link read of a dispatch.
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int TIMEOUT_NS    = 2_000_000;

	// Two copies of the shadow scheduler: one advances as commands transfer,
	// the other runs ahead while the stimulus is planned.
	localparam int LIVE = 0;
	localparam int PLAN = 1;

	typedef logic [aepq_pkg::ID_W-1:0]  id_t;
	typedef logic [aepq_pkg::LVL_W-1:0] lvl_t;
	typedef logic [aepq_pkg::CFG_W-1:0] cfg_t;

	// One entry of the stimulus plan: a command or a level count write
	typedef struct packed {
		logic is_cfg;
		cfg_t cfg_val;
		logic op;
		id_t  id;
		lvl_t lvl;
		logic ex;
	} cmd_t;

	typedef struct packed {
		logic found;
		id_t  id;
		lvl_t lvl;
		logic swapped;
		logic refused;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_t cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic op = aepq_pkg::OP_ADD;
	id_t  task_id = '0;
	lvl_t level = '0;
	logic expired = 1'b0;
	logic done;
	logic found;
	id_t  chosen_id;
	lvl_t chosen_level;
	logic banks_swapped;
	logic refused;

	// Shadow scheduler state, indexed by copy
	id_t  task_link [2][MAX_TASKS];
	id_t  lvl_head [2][2*MAX_LEVELS];
	id_t  lvl_tail [2][2*MAX_LEVELS];
	bit   lvl_full [2][2*MAX_LEVELS];
	bit   run_bank [2];
	cfg_t lvl_count [2];
	// Bookkeeping used by the planner to keep link reads on written entries
	bit   link_ok [2][MAX_TASKS];
	int   queued_copies [2][MAX_TASKS];
	int   links_set [2];

	cmd_t     plan_q [$];
	outcome_t pending_results [$];

	// Driver state
	cmd_t cur;
	bit   holding = 1'b0;
	bit   write_now = 1'b0;
	int   in_flight = 0;
	int   settle = 0;
	int   transfers = 0;

	int mismatches = 0;

	active_expired_priority_queues #(
		.MAX_LEVELS(MAX_LEVELS),
		.MAX_TASKS (MAX_TASKS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.task_id      (task_id),
		.level        (level),
		.expired      (expired),
		.done         (done),
		.found        (found),
		.chosen_id    (chosen_id),
		.chosen_level (chosen_level),
		.banks_swapped(banks_swapped),
		.refused      (refused)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow scheduler
	// ------------------------------------------------------------------------

	// Level counts above the table size behave as the full table
	function automatic int usable_levels(input int c);
		return (lvl_count[c] > MAX_LEVELS) ? MAX_LEVELS : int'(lvl_count[c]);
	endfunction

	// Pop the oldest task of the highest non-empty level in the running bank
	function automatic bit take_top(input int c, output id_t id, output lvl_t lvl);
		int l;
		int q;
		id_t h;
		id = '0;
		lvl = '0;
		for (l = usable_levels(c) - 1; l >= 0; l--) begin
			q = int'(run_bank[c]) * MAX_LEVELS + l;
			if (lvl_full[c][q]) begin
				h = lvl_head[c][q];
				id = h;
				lvl = l[aepq_pkg::LVL_W-1:0];
				// Head equal to tail closes the queue, even if the id was queued
				// again further back.
				if (h == lvl_tail[c][q])
					lvl_full[c][q] = 1'b0;
				else
					lvl_head[c][q] = task_link[c][h];
				queued_copies[c][h]--;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Advance one copy of the scheduler by one command and return its result
	function automatic outcome_t schedule_cmd(input int c, input cmd_t cmd);
		outcome_t res;
		id_t id;
		lvl_t lvl;
		id_t t;
		int q;
		bit got;
		res = '0;
		if (cmd.op == aepq_pkg::OP_ADD) begin
			if (cmd.lvl >= usable_levels(c)) begin
				res.refused = 1'b1;
				return res;
			end
			q = int'(run_bank[c] ^ cmd.ex) * MAX_LEVELS + cmd.lvl;
			if (lvl_full[c][q]) begin
				t = lvl_tail[c][q];
				task_link[c][t] = cmd.id;
				if (!link_ok[c][t]) begin
					link_ok[c][t] = 1'b1;
					links_set[c]++;
				end
			end else begin
				lvl_head[c][q] = cmd.id;
				lvl_full[c][q] = 1'b1;
			end
			lvl_tail[c][q] = cmd.id;
			queued_copies[c][cmd.id]++;
		end else begin
			got = take_top(c, id, lvl);
			// Running bank empty: swap the banks and search once more
			if (!got) begin
				run_bank[c] = !run_bank[c];
				res.swapped = 1'b1;
				got = take_top(c, id, lvl);
			end
			if (got) begin
				res.found = 1'b1;
				res.id = id;
				res.lvl = lvl;
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------------

	task automatic plan_cmd(input logic o, input id_t id, input lvl_t lvl, input logic ex);
		cmd_t cmd;
		outcome_t ignored;
		cmd = '0;
		cmd.op = o;
		cmd.id = id;
		cmd.lvl = lvl;
		cmd.ex = ex;
		ignored = schedule_cmd(PLAN, cmd);
		plan_q = {plan_q, cmd};
	endtask

	task automatic plan_cfg(input cfg_t val);
		cmd_t cmd;
		cmd = '0;
		cmd.is_cfg = 1'b1;
		cmd.cfg_val = val;
		lvl_count[PLAN] = val;
		plan_q = {plan_q, cmd};
	endtask

	// One random command. Until every link entry has been written, an id goes
	// into one queue slot at a time, so no dispatch can follow a link that was
	// never written; ids whose link is still unwritten are preferred. After
	// that, any id may be queued again.
	task automatic plan_random(input int add_pct);
		id_t id;
		lvl_t lvl;
		int lim;
		int k;
		int base;
		int cand;
		bit picked;
		lim = usable_levels(PLAN);
		id = id_t'($urandom_range(MAX_TASKS - 1));
		picked = 1'b1;
		if (links_set[PLAN] < MAX_TASKS &&
				(queued_copies[PLAN][id] != 0 || $urandom_range(1) == 1)) begin
			picked = 1'b0;
			base = $urandom_range(MAX_TASKS - 1);
			// First lap: free ids with an unwritten link; second lap: any free id
			for (k = 0; k < 2 * MAX_TASKS && !picked; k++) begin
				cand = (base + k) % MAX_TASKS;
				if (queued_copies[PLAN][cand] == 0 &&
						(k >= MAX_TASKS || !link_ok[PLAN][cand])) begin
					id = cand[aepq_pkg::ID_W-1:0];
					picked = 1'b1;
				end
			end
		end
		if (picked && $urandom_range(99) < add_pct) begin
			// Mostly levels in range; now and then any level, to draw refusals
			if (lim == 0 || $urandom_range(9) == 0)
				lvl = lvl_t'($urandom_range(15));
			else
				lvl = lvl_t'($urandom_range(lim - 1));
			plan_cmd(aepq_pkg::OP_ADD, id, lvl, 1'($urandom_range(1)));
		end else begin
			// Dispatch ignores id, level and flag; keep them random
			plan_cmd(aepq_pkg::OP_DISPATCH, 8'($urandom_range(255)),
				4'($urandom_range(15)), 1'($urandom_range(1)));
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: presents planned commands, writes the level count when quiet
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			cfg_wdata <= '0;
			op <= aepq_pkg::OP_ADD;
			task_id <= '0;
			level <= '0;
			expired <= 1'b0;
			holding = 1'b0;
			in_flight = 0;
			settle = 0;
		end else begin
			// Command transfer at this edge: predict its result now
			if (start && !busy) begin
				pending_results.insert(pending_results.size(), schedule_cmd(LIVE, cur));
				holding = 1'b0;
				in_flight++;
				transfers++;
			end
			if (done && in_flight > 0)
				in_flight--;
			// A level count write took effect at this edge
			if (cfg_we)
				lvl_count[LIVE] = cfg_wdata;

			// Count quiet cycles: nothing presented, nothing owed, block idle
			if (!holding && !cfg_we && in_flight == 0 && !busy)
				settle++;
			else
				settle = 0;

			write_now = 1'b0;
			if (!holding && plan_q.size() != 0) begin
				if (plan_q[0].is_cfg) begin
					// Hold register writes until the block has drained
					if (settle >= SETTLE_CYCLES) begin
						cur = plan_q[0];
						plan_q.delete(0);
						write_now = 1'b1;
						settle = 0;
					end
				end else if ((transfers >= CALM_FROM && transfers < CALM_TO) ||
						$urandom_range(99) >= IDLE_PCT) begin
					// Raise start right away, even while busy, so the next
					// transfer lands on the first free edge
					cur = plan_q[0];
					plan_q.delete(0);
					holding = 1'b1;
				end
			end

			start <= holding;
			cfg_we <= write_now;
			if (write_now)
				cfg_wdata <= cur.cfg_val;
			if (holding) begin
				op <= cur.op;
				task_id <= cur.id;
				level <= cur.lvl;
				expired <= cur.ex;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every done pulse must match the oldest prediction
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input id_t want, input id_t got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t ns: result expected none, got id %0h level %0h",
					$time, chosen_id, chosen_level);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				check_field("found", id_t'(want.found), id_t'(found));
				check_field("chosen_id", want.id, chosen_id);
				check_field("chosen_level", id_t'(want.lvl), id_t'(chosen_level));
				check_field("banks_swapped", id_t'(want.swapped), id_t'(banks_swapped));
				check_field("refused", id_t'(want.refused), id_t'(refused));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Plan, reset, run to completion, verdict
	// ------------------------------------------------------------------------
	initial begin
		int c;
		int i;
		int p;
		int phase_lv [7];
		int phase_len [7];

		for (c = 0; c < 2; c++) begin
			for (i = 0; i < MAX_TASKS; i++) begin
				task_link[c][i] = '0;
				link_ok[c][i] = 1'b0;
				queued_copies[c][i] = 0;
			end
			for (i = 0; i < 2 * MAX_LEVELS; i++) begin
				lvl_head[c][i] = '0;
				lvl_tail[c][i] = '0;
				lvl_full[c][i] = 1'b0;
			end
			run_bank[c] = 1'b0;
			lvl_count[c] = aepq_pkg::NUM_LEVELS_RST;
			links_set[c] = 0;
		end

		// Directed part, starting from the reset count of four levels.
		// Dispatch on empty banks: swap, nothing found.
		plan_cmd(aepq_pkg::OP_DISPATCH, 8'hFF, 4'hF, 1'b1);
		// Fill both banks at the field extremes
		plan_cmd(aepq_pkg::OP_ADD, 8'h00, 4'd0, 1'b0);
		plan_cmd(aepq_pkg::OP_ADD, 8'hFF, 4'd3, 1'b0);
		plan_cmd(aepq_pkg::OP_ADD, 8'h5A, 4'd3, 1'b1);
		plan_cmd(aepq_pkg::OP_ADD, 8'hA5, 4'd1, 1'b0);
		// Level at the count and at the field maximum: refused
		plan_cmd(aepq_pkg::OP_ADD, 8'h11, 4'd4, 1'b0);
		plan_cmd(aepq_pkg::OP_ADD, 8'h22, 4'd15, 1'b1);
		// Drain highest first, then swap into the expired bank, then swap on empty
		repeat (5) plan_cmd(aepq_pkg::OP_DISPATCH, 8'h00, 4'h0, 1'b0);
		// Same id queued twice at one level: its link points to itself
		plan_cmd(aepq_pkg::OP_ADD, 8'h33, 4'd2, 1'b0);
		plan_cmd(aepq_pkg::OP_ADD, 8'h33, 4'd2, 1'b0);
		repeat (2) plan_cmd(aepq_pkg::OP_DISPATCH, 8'h00, 4'h0, 1'b0);
		// Zero levels: every add refused, every dispatch swaps
		plan_cfg(5'd0);
		plan_cmd(aepq_pkg::OP_ADD, 8'h44, 4'd0, 1'b0);
		plan_cmd(aepq_pkg::OP_DISPATCH, 8'h00, 4'h0, 1'b0);
		// Full table, then a count above it
		plan_cfg(5'd16);
		plan_cmd(aepq_pkg::OP_ADD, 8'h66, 4'd15, 1'b0);
		plan_cmd(aepq_pkg::OP_ADD, 8'h77, 4'd0, 1'b1);
		plan_cmd(aepq_pkg::OP_DISPATCH, 8'h00, 4'h0, 1'b0);
		plan_cfg(5'd31);
		plan_cmd(aepq_pkg::OP_ADD, 8'h88, 4'd15, 1'b0);
		plan_cmd(aepq_pkg::OP_DISPATCH, 8'h00, 4'h0, 1'b0);
		// Single level
		plan_cfg(5'd1);
		plan_cmd(aepq_pkg::OP_ADD, 8'h99, 4'd1, 1'b0);
		plan_cmd(aepq_pkg::OP_ADD, 8'h9A, 4'd0, 1'b0);
		plan_cmd(aepq_pkg::OP_DISPATCH, 8'h00, 4'h0, 1'b0);

		// Random part. The first phase is add-heavy over the full table so
		// the link memory gets written throughout; repeated ids follow.
		plan_cfg(5'd16);
		repeat (700) plan_random(62);
		phase_lv = '{1, 31, 0, $urandom_range(2, 15), 16, 17, $urandom_range(2, 15)};
		phase_len = '{120, 150, 40, 150, 150, 120, 100};
		for (p = 0; p < 7; p++) begin
			plan_cfg(phase_lv[p][aepq_pkg::CFG_W-1:0]);
			repeat (phase_len[p]) plan_random(55);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the plan to drain and every prediction to be met
		do
			@(negedge clk);
		while (plan_q.size() != 0 || holding || pending_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("active_expired_priority_queues: match");
		else
			$display("active_expired_priority_queues: mismatch");
		$finish;
	end

	// Watchdog: a stuck handshake or a missing result ends the run here
	initial begin
		#(TIMEOUT_NS);
		$display("active_expired_priority_queues: mismatch");
		$finish;
	end

endmodule

/* files.f */
src/aepq_pkg.sv
src/aepq_pick.sv
src/aepq_store.sv
src/active_expired_priority_queues.sv
tb/sv/tb.sv
